>>> rtl/core/hmsha1_pkg.sv
// ============================================================================
// hmsha1_pkg
// Shared types, constants and helper functions for the HMAC-SHA1 engine.
// ============================================================================
package hmsha1_pkg;

    // Input item kinds carried in s_tuser.
    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // SHA-1 initial chaining words.
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    // SHA-1 round constants.
    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5c;
    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] NO_MASK   = 8'h00;

    localparam int unsigned ROUNDS = 80;

    typedef logic [4:0][31:0] digest_t;

    // Source of the byte written into the message block.
    typedef enum logic [2:0] {
        SRC_SBYTE = 3'd0,
        SRC_HOLD  = 3'd1,
        SRC_KEY   = 3'd2,
        SRC_PAD   = 3'd3,
        SRC_ZERO  = 3'd4,
        SRC_LEN   = 3'd5,
        SRC_INNER = 3'd6
    } src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       absorb;
        logic       count_inc;
        src_t       src;
        logic [7:0] kmask;
        logic       load_iv;
        logic       hold_load;
        logic       key_wr;
        logic       key_cnt_inc;
        logic       idx_clr;
        logic       idx_inc;
        logic       kclear;
        logic       kcopy;
        logic       save_inner;
        logic       clear_all;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
        logic kc_lt64;
        logic kc_eq64;
        logic pos_is56;
        logic pos_is63;
        logic idx_is4;
        logic idx_is19;
        logic idx_is63;
    } stat_t;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
        rol32 = (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] digest_word(input digest_t d, input logic [2:0] i);
        logic [31:0] w;
        unique case (i)
            3'd0:    w = d[0];
            3'd1:    w = d[1];
            3'd2:    w = d[2];
            3'd3:    w = d[3];
            default: w = d[4];
        endcase
        digest_word = w;
    endfunction

    // Big-endian byte i (0..19) of a five-word digest.
    function automatic logic [7:0] digest_byte(input digest_t d, input logic [4:0] i);
        logic [31:0] w;
        w = digest_word(d, i[4:2]);
        digest_byte = w[{~i[1:0], 3'b000} +: 8];
    endfunction

endpackage

>>> rtl/core/hmac_sha1_engine.sv
// ============================================================================
// hmac_sha1_engine
// Streaming HMAC-SHA1 engine with an internal 64-byte key store.
// ============================================================================
// Send key beats (tuser 0) first, then data beats (tuser 1), then one finish
// beat (tuser 2); the engine then returns the five big-endian digest words on
// the master side, word 0 first, with tlast on word 4, and clears itself so
// the next beat starts a new key. Every 64th byte absorbed into the SHA-1
// block starts a compression that holds s_tready low during its 80 rounds
// through the single round unit plus the chain update, so no new byte is
// taken while a block is being hashed. The first data beat also hashes the
// 64-byte inner key pad, after first reducing a key longer than 64 bytes to
// its digest. A finish beat runs the inner padding, the outer key pad, the
// inner digest and the outer padding before word 0 appears; when it comes
// straight after the key, it also hashes the inner key pad (and reduces a
// long key) first. Only one beat is worked on at a time; s_tready stays low
// until its work and any digest output are done. Beats with tuser 3, and key
// beats after data has started, are accepted and ignored.
// ============================================================================
module hmac_sha1_engine
    import hmsha1_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);

    cmd_t  cmd;
    stat_t stat;

    // The controller decides what happens to each beat and walks the
    // padding and key-pad sequences.
    hmsha1_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .m_tready (m_tready),
        .stat     (stat),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    // The datapath holds the key store, the block window and the round unit.
    hmsha1_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_byte    (s_tdata),
        .stat      (stat),
        .out_word  (m_tdata),
        .out_index (m_tuser)
    );

    assign m_tlast = (m_tuser == 3'd4);

`ifndef SYNTHESIS
    // The engine never takes a new beat while a digest word is offered.
    a_no_input_during_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while digest output pending");

    // After the last word is taken, output stops.
    a_stop_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output continued after last digest word");

    // Words come in order without gaps.
    a_word_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tuser == $past(m_tuser) + 3'd1)))
        else $error("digest words out of order");

    // A new digest always starts at word zero.
    a_first_word: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> (m_tuser == 3'd0))
        else $error("digest output did not start at word zero");
`endif

endmodule

>>> rtl/core/hmsha1_dp.sv
// ============================================================================
// hmsha1_dp
// Datapath: key store, message block window, SHA-1 round engine, counters.
// ============================================================================
module hmsha1_dp
    import hmsha1_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    input  logic [7:0]  s_byte,
    output stat_t       stat,
    output logic [31:0] out_word,
    output logic [2:0]  out_index
);

    logic [15:0][31:0] w_reg, w_next;
    digest_t           h_reg, h_next;
    digest_t           v_reg, v_next;
    digest_t           inner_reg;
    logic [6:0]        round_reg, round_next;
    logic              comp_reg, comp_next;
    logic [5:0]        pos_reg, pos_next;
    logic [63:0]       msg_reg, msg_next;
    logic [63:0]       kc_reg, kc_next;
    logic [5:0]        idx_reg, idx_next;
    logic [7:0]        hold_reg;

    logic [7:0]        key_mem [64];
    logic [63:0]       kvalid_reg, kvalid_next;
    logic [7:0]        rd_data_reg;
    logic              rd_valid_reg;
    logic              mem_we;
    logic [5:0]        mem_waddr;
    logic [7:0]        mem_wdata;

    logic [7:0]        abs_byte;
    logic [63:0]       len_bits;
    logic [31:0]       f_val, k_val, t_sum, w_new;

    assign len_bits = {msg_reg[60:0], 3'b000};

    always_comb begin
        unique case (cmd.src)
            SRC_SBYTE: abs_byte = s_byte;
            SRC_HOLD:  abs_byte = hold_reg;
            SRC_KEY:   abs_byte = (rd_valid_reg ? rd_data_reg : 8'h00) ^ cmd.kmask;
            SRC_PAD:   abs_byte = PAD_BYTE;
            SRC_LEN:   abs_byte = len_bits[{~pos_reg[2:0], 3'b000} +: 8];
            SRC_INNER: abs_byte = digest_byte(inner_reg, idx_reg[4:0]);
            default:   abs_byte = 8'h00;
        endcase
    end

    // Round function and constant by round range.
    always_comb begin
        if (round_reg < 7'd20) begin
            f_val = (v_reg[1] & v_reg[2]) ^ (~v_reg[1] & v_reg[3]);
            k_val = K0;
        end else if (round_reg < 7'd40) begin
            f_val = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k_val = K1;
        end else if (round_reg < 7'd60) begin
            f_val = (v_reg[1] & v_reg[2]) ^ (v_reg[1] & v_reg[3]) ^ (v_reg[2] & v_reg[3]);
            k_val = K2;
        end else begin
            f_val = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k_val = K3;
        end
        t_sum = rol32(v_reg[0], 5) + f_val + v_reg[4] + k_val + w_reg[0];
        w_new = rol32(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);
    end

    always_comb begin
        w_next     = w_reg;
        h_next     = h_reg;
        v_next     = v_reg;
        round_next = round_reg;
        comp_next  = comp_reg;
        pos_next   = pos_reg;
        msg_next   = msg_reg;
        kc_next    = kc_reg;
        kvalid_next = kvalid_reg;

        if (comp_reg) begin
            if (round_reg == 7'(ROUNDS)) begin
                for (int i = 0; i < 5; i++) begin
                    h_next[i] = h_reg[i] + v_reg[i];
                end
                comp_next = 1'b0;
            end else begin
                v_next[0] = t_sum;
                v_next[1] = v_reg[0];
                v_next[2] = rol32(v_reg[1], 30);
                v_next[3] = v_reg[2];
                v_next[4] = v_reg[3];
                for (int i = 0; i < 15; i++) begin
                    w_next[i] = w_reg[i + 1];
                end
                w_next[15] = w_new;
                round_next = round_reg + 7'd1;
            end
        end

        if (cmd.absorb) begin
            w_next[pos_reg[5:2]][{~pos_reg[1:0], 3'b000} +: 8] = abs_byte;
            pos_next = pos_reg + 6'd1;
            if (cmd.count_inc) begin
                msg_next = msg_reg + 64'd1;
            end
            if (pos_reg == 6'd63) begin
                v_next     = h_reg;
                round_next = '0;
                comp_next  = 1'b1;
            end
        end

        if (cmd.load_iv) begin
            h_next   = {IV4, IV3, IV2, IV1, IV0};
            pos_next = '0;
            msg_next = '0;
        end

        if (cmd.key_cnt_inc) begin
            kc_next = kc_reg + 64'd1;
        end
        if (cmd.key_wr) begin
            kvalid_next[kc_reg[5:0]] = 1'b1;
        end
        if (cmd.kclear) begin
            kvalid_next = '0;
        end
        if (cmd.kcopy) begin
            kvalid_next[idx_reg] = 1'b1;
        end

        if (cmd.clear_all) begin
            h_next      = {IV4, IV3, IV2, IV1, IV0};
            v_next      = '0;
            comp_next   = 1'b0;
            pos_next    = '0;
            msg_next    = '0;
            kc_next     = '0;
            kvalid_next = '0;
        end
    end

    always_comb begin
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + 6'd1;
        end else begin
            idx_next = idx_reg;
        end
    end

    assign mem_we    = cmd.key_wr | cmd.kcopy;
    assign mem_waddr = cmd.kcopy ? idx_reg : kc_reg[5:0];
    assign mem_wdata = cmd.kcopy ? digest_byte(h_reg, idx_reg[4:0]) : s_byte;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= key_mem[idx_next];
    end

    always_ff @(posedge aclk) begin
        w_reg <= w_next;
        v_reg <= v_next;
        if (cmd.hold_load) begin
            hold_reg <= s_byte;
        end
        if (cmd.save_inner) begin
            inner_reg <= h_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg        <= {IV4, IV3, IV2, IV1, IV0};
            round_reg    <= '0;
            comp_reg     <= 1'b0;
            pos_reg      <= '0;
            msg_reg      <= '0;
            kc_reg       <= '0;
            idx_reg      <= '0;
            kvalid_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            h_reg        <= h_next;
            round_reg    <= round_next;
            comp_reg     <= comp_next;
            pos_reg      <= pos_next;
            msg_reg      <= msg_next;
            kc_reg       <= kc_next;
            idx_reg      <= idx_next;
            kvalid_reg   <= kvalid_next;
            rd_valid_reg <= kvalid_next[idx_next] & kvalid_reg[idx_next];
        end
    end

    assign stat.busy     = comp_reg;
    assign stat.kc_lt64  = ~|kc_reg[63:6];
    assign stat.kc_eq64  = (kc_reg == 64'd64);
    assign stat.pos_is56 = (pos_reg == 6'd56);
    assign stat.pos_is63 = (pos_reg == 6'd63);
    assign stat.idx_is4  = (idx_reg == 6'd4);
    assign stat.idx_is19 = (idx_reg == 6'd19);
    assign stat.idx_is63 = (idx_reg == 6'd63);

    assign out_word  = digest_word(h_reg, idx_reg[2:0]);
    assign out_index = idx_reg[2:0];

endmodule

>>> rtl/core/hmsha1_ctrl.sv
// ============================================================================
// hmsha1_ctrl
// Controller: sequences key handling, padding, inner and outer hashes.
// ============================================================================
module hmsha1_ctrl
    import hmsha1_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [1:0] s_kind,
    input  logic       m_tready,
    input  stat_t      stat,
    output logic       s_tready,
    output logic       m_tvalid,
    output cmd_t       cmd
);

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_KSTREAM = 11'b000_0000_0010,
        ST_HOLDABS = 11'b000_0000_0100,
        ST_BEGIN   = 11'b000_0000_1000,
        ST_PAD80   = 11'b000_0001_0000,
        ST_PADZ    = 11'b000_0010_0000,
        ST_PADLEN  = 11'b000_0100_0000,
        ST_KCOPY   = 11'b000_1000_0000,
        ST_SAVE    = 11'b001_0000_0000,
        ST_ISTREAM = 11'b010_0000_0000,
        ST_OUT     = 11'b100_0000_0000
    } state_t;

    typedef enum logic [1:0] {KCTX_RAW, KCTX_IPAD, KCTX_OPAD} kctx_t;
    typedef enum logic [1:0] {PCTX_KEY, PCTX_INNER, PCTX_OUTER} pctx_t;

    state_t state_reg, state_next;
    kctx_t  kctx_reg, kctx_next;
    pctx_t  pctx_reg, pctx_next;
    logic   phase_data_reg, phase_data_next;
    logic   fin_reg, fin_next;
    logic   s_acc;

    assign s_tready = (state_reg == ST_IDLE) && !stat.busy;
    assign m_tvalid = (state_reg == ST_OUT) && !stat.busy;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        cmd             = '0;
        state_next      = state_reg;
        kctx_next       = kctx_reg;
        pctx_next       = pctx_reg;
        phase_data_next = phase_data_reg;
        fin_next        = fin_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    cmd.hold_load = 1'b1;
                    priority if (s_kind == KIND_KEY) begin
                        if (!phase_data_reg) begin
                            cmd.key_cnt_inc = 1'b1;
                            if (stat.kc_lt64) begin
                                cmd.key_wr = 1'b1;
                            end else if (stat.kc_eq64) begin
                                // 65th key byte: start hashing the whole key.
                                cmd.load_iv = 1'b1;
                                cmd.idx_clr = 1'b1;
                                kctx_next   = KCTX_RAW;
                                state_next  = ST_KSTREAM;
                            end else begin
                                cmd.absorb    = 1'b1;
                                cmd.count_inc = 1'b1;
                                cmd.src       = SRC_SBYTE;
                            end
                        end
                    end else if (s_kind == KIND_DATA) begin
                        if (phase_data_reg) begin
                            cmd.absorb    = 1'b1;
                            cmd.count_inc = 1'b1;
                            cmd.src       = SRC_SBYTE;
                        end else begin
                            fin_next   = 1'b0;
                            state_next = ST_BEGIN;
                        end
                    end else if (s_kind == KIND_FINISH) begin
                        fin_next = 1'b1;
                        if (phase_data_reg) begin
                            pctx_next  = PCTX_INNER;
                            state_next = ST_PAD80;
                        end else begin
                            state_next = ST_BEGIN;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BEGIN: begin
                if (!stat.kc_lt64 && !stat.kc_eq64) begin
                    pctx_next  = PCTX_KEY;
                    state_next = ST_PAD80;
                end else if (!stat.busy) begin
                    cmd.load_iv = 1'b1;
                    cmd.idx_clr = 1'b1;
                    kctx_next   = KCTX_IPAD;
                    state_next  = ST_KSTREAM;
                end
            end
            ST_KSTREAM: begin
                if (!stat.busy) begin
                    cmd.absorb    = 1'b1;
                    cmd.count_inc = 1'b1;
                    cmd.src       = SRC_KEY;
                    unique case (kctx_reg)
                        KCTX_IPAD: cmd.kmask = IPAD_BYTE;
                        KCTX_OPAD: cmd.kmask = OPAD_BYTE;
                        default:   cmd.kmask = NO_MASK;
                    endcase
                    if (stat.idx_is63) begin
                        cmd.idx_clr = 1'b1;
                        unique case (kctx_reg)
                            KCTX_IPAD: begin
                                phase_data_next = 1'b1;
                                if (fin_reg) begin
                                    pctx_next  = PCTX_INNER;
                                    state_next = ST_PAD80;
                                end else begin
                                    state_next = ST_HOLDABS;
                                end
                            end
                            KCTX_OPAD: state_next = ST_ISTREAM;
                            default:   state_next = ST_HOLDABS;
                        endcase
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_HOLDABS: begin
                if (!stat.busy) begin
                    cmd.absorb    = 1'b1;
                    cmd.count_inc = 1'b1;
                    cmd.src       = SRC_HOLD;
                    state_next    = ST_IDLE;
                end
            end
            ST_PAD80: begin
                if (!stat.busy) begin
                    cmd.absorb = 1'b1;
                    cmd.src    = SRC_PAD;
                    state_next = ST_PADZ;
                end
            end
            ST_PADZ: begin
                if (!stat.busy) begin
                    if (stat.pos_is56) begin
                        state_next = ST_PADLEN;
                    end else begin
                        cmd.absorb = 1'b1;
                        cmd.src    = SRC_ZERO;
                    end
                end
            end
            ST_PADLEN: begin
                if (!stat.busy) begin
                    cmd.absorb = 1'b1;
                    cmd.src    = SRC_LEN;
                    if (stat.pos_is63) begin
                        cmd.idx_clr = 1'b1;
                        unique case (pctx_reg)
                            PCTX_KEY: begin
                                cmd.kclear = 1'b1;
                                state_next = ST_KCOPY;
                            end
                            PCTX_INNER: state_next = ST_SAVE;
                            default:    state_next = ST_OUT;
                        endcase
                    end
                end
            end
            ST_KCOPY: begin
                if (!stat.busy) begin
                    cmd.kcopy = 1'b1;
                    if (stat.idx_is19) begin
                        cmd.idx_clr = 1'b1;
                        cmd.load_iv = 1'b1;
                        kctx_next   = KCTX_IPAD;
                        state_next  = ST_KSTREAM;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_SAVE: begin
                if (!stat.busy) begin
                    cmd.save_inner = 1'b1;
                    cmd.load_iv    = 1'b1;
                    cmd.idx_clr    = 1'b1;
                    kctx_next      = KCTX_OPAD;
                    state_next     = ST_KSTREAM;
                end
            end
            ST_ISTREAM: begin
                if (!stat.busy) begin
                    cmd.absorb    = 1'b1;
                    cmd.count_inc = 1'b1;
                    cmd.src       = SRC_INNER;
                    if (stat.idx_is19) begin
                        cmd.idx_clr = 1'b1;
                        pctx_next   = PCTX_OUTER;
                        state_next  = ST_PAD80;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (m_tvalid && m_tready) begin
                    if (stat.idx_is4) begin
                        cmd.clear_all   = 1'b1;
                        cmd.idx_clr     = 1'b1;
                        phase_data_next = 1'b0;
                        state_next      = ST_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            kctx_reg       <= KCTX_RAW;
            pctx_reg       <= PCTX_KEY;
            phase_data_reg <= 1'b0;
            fin_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            kctx_reg       <= kctx_next;
            pctx_reg       <= pctx_next;
            phase_data_reg <= phase_data_next;
            fin_reg        <= fin_next;
        end
    end

endmodule

>>> sim/tb_hmac_sha1_engine.sv
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine testbench
// Streams key, data and finish beats into the engine with random gaps on both
// sides and checks every digest word against a behavioral HMAC-SHA1 predictor.
// ----------------------------------------------------------------------------
module tb_hmac_sha1_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import hmsha1_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    // Predicts HMAC-SHA1 results and holds the digest words still awaited.
    class digest_scoreboard;
        logic [31:0]  chain[5];
        logic [31:0]  wnd[16];
        logic [7:0]   key_bytes[64];
        logic [63:0]  key_len;
        logic [63:0]  msg_len;
        bit           in_data;
        digest_beat_t pending[$];
        int           mismatches;

        function void clear_state();
            chain = '{IV0, IV1, IV2, IV3, IV4};
            foreach (wnd[i]) wnd[i] = '0;
            foreach (key_bytes[i]) key_bytes[i] = '0;
            key_len = '0;
            msg_len = '0;
            in_data = 0;
        endfunction

        function new();
            clear_state();
            mismatches = 0;
        endfunction

        function logic [31:0] rotl(logic [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void compress();
            logic [31:0] a, b, c, d, e, f, k, t;
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
            for (int r = 0; r < 80; r++) begin
                if (r >= 16)
                    wnd[r & 15] = rotl(wnd[(r - 3) & 15] ^ wnd[(r - 8) & 15]
                                       ^ wnd[(r - 14) & 15] ^ wnd[r & 15], 1);
                if (r < 20) begin
                    f = (b & c) ^ (~b & d); k = K0;
                end else if (r < 40) begin
                    f = b ^ c ^ d; k = K1;
                end else if (r < 60) begin
                    f = (b & c) ^ (b & d) ^ (c & d); k = K2;
                end else begin
                    f = b ^ c ^ d; k = K3;
                end
                t = rotl(a, 5) + f + e + k + wnd[r & 15];
                e = d; d = c; c = rotl(b, 30); b = a; a = t;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
        endfunction

        function void put_byte(int pos, logic [7:0] v);
            wnd[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = v;
            if (pos == 63) compress();
        endfunction

        function void absorb(logic [7:0] v);
            put_byte(int'(msg_len[5:0]), v);
            msg_len++;
        endfunction

        function void pad_close();
            logic [63:0] bits;
            int pos;
            bits = msg_len << 3;
            pos = int'(msg_len[5:0]);
            put_byte(pos, PAD_BYTE);
            pos = (pos + 1) & 63;
            while (pos != 56) begin
                put_byte(pos, 8'h00);
                pos = (pos + 1) & 63;
            end
            for (int i = 0; i < 8; i++) put_byte(56 + i, bits[(7 - i) * 8 +: 8]);
        endfunction

        function void restart_hash();
            chain = '{IV0, IV1, IV2, IV3, IV4};
            msg_len = '0;
        endfunction

        function void start_inner();
            if (key_len > 64) begin
                // Long key: its SHA-1 digest, zero padded, becomes the key.
                pad_close();
                foreach (key_bytes[i]) key_bytes[i] = '0;
                for (int i = 0; i < 20; i++)
                    key_bytes[i] = chain[i >> 2][(3 - (i & 3)) * 8 +: 8];
            end
            restart_hash();
            for (int i = 0; i < 64; i++) absorb(key_bytes[i] ^ IPAD_BYTE);
            in_data = 1;
        endfunction

        function void note_beat(logic [1:0] kind, logic [7:0] v);
            logic [31:0] inner[5];
            digest_beat_t db;
            case (kind)
                KIND_KEY: begin
                    if (in_data) return;
                    if (key_len < 64) key_bytes[key_len[5:0]] = v;
                    else begin
                        if (key_len == 64) begin
                            restart_hash();
                            for (int i = 0; i < 64; i++) absorb(key_bytes[i]);
                        end
                        absorb(v);
                    end
                    key_len++;
                end
                KIND_DATA: begin
                    if (!in_data) start_inner();
                    absorb(v);
                end
                KIND_FINISH: begin
                    if (!in_data) start_inner();
                    pad_close();
                    inner = chain;
                    restart_hash();
                    for (int i = 0; i < 64; i++) absorb(key_bytes[i] ^ OPAD_BYTE);
                    for (int i = 0; i < 20; i++) absorb(inner[i >> 2][(3 - (i & 3)) * 8 +: 8]);
                    pad_close();
                    for (int i = 0; i < 5; i++) begin
                        db.word = chain[i];
                        db.index = 3'(i);
                        db.last = (i == 4);
                        pending.push_back(db);
                    end
                    clear_state();
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [31:0] w, logic [2:0] idx, logic last);
            digest_beat_t exp_beat;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected digest beat %h", w);
                return;
            end
            exp_beat = pending.pop_front();
            if (exp_beat.word !== w || exp_beat.index !== idx || exp_beat.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                             exp_beat.word, exp_beat.index, exp_beat.last, w, idx, last);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    digest_scoreboard sb = new();
    int  beats_sent = 0;
    bit  hold_off = 0;   // sink holds m_tready low while set

    always #5 aclk = ~aclk;

    hmac_sha1_engine DUT (.*);

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one beat and wait for its handshake; the predictor sees it on accept.
    // tvalid stays up after the handshake so a following beat can go out at
    // once; a gap or an explicit pause drops it.
    task automatic send_beat(logic [1:0] kind, logic [7:0] v, bit allow_gap = 1);
        int g;
        g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= kind;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(kind, v);
        beats_sent++;
    endtask

    // Drop tvalid.
    task automatic pause_bus();
        s_tvalid <= 0;
        @(posedge aclk);
    endtask

    task automatic send_key(int len, bit pattern_ff = 0);
        for (int i = 0; i < len; i++)
            send_beat(KIND_KEY, pattern_ff ? 8'hff : 8'($urandom_range(0, 255)));
    endtask

    task automatic send_data(int len);
        for (int i = 0; i < len; i++) send_beat(KIND_DATA, 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        pause_bus();
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    // Sink: random stalls, plus a long hold-off requested by the stimulus.
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off) m_tready <= 0;
            else begin
                g = gap_len();
                if (g > 0) begin
                    m_tready <= 0;
                    repeat (g) @(posedge aclk);
                end
                m_tready <= 1;
            end
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser, m_tlast);

    initial begin
        int sel;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty key and empty message.
        send_beat(KIND_FINISH, 8'h00);
        // Exactly 64 key bytes, all-ones and all-zero data, a dropped late key byte.
        send_key(64, 1);
        send_beat(KIND_DATA, 8'hff);
        send_beat(KIND_DATA, 8'h00);
        send_beat(KIND_KEY, 8'haa);
        send_beat(KIND_UNUSED, 8'h55);
        send_beat(KIND_FINISH, 8'hff);
        // The sender pauses until every digest word is back.
        wait_drained();
        // Key longer than 64 bytes gets hashed down.
        send_key(65);
        send_data(3);
        send_beat(KIND_FINISH, 8'h12);
        // Unused kind inside the key phase, then a key-only run.
        send_key(3);
        send_beat(KIND_UNUSED, 8'hff);
        send_beat(KIND_FINISH, 8'h00);

        // The sink holds off for a long stretch while beats keep coming, so
        // the engine holds its digest and stalls its input.
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge aclk);
                hold_off = 0;
            end
            begin
                send_key(5);
                send_data(2);
                send_beat(KIND_FINISH, 8'h00, 0);
                send_data(4);
                send_beat(KIND_FINISH, 8'h00, 0);
                pause_bus();
            end
        join

        // Random messages: mostly well-formed key/data/finish runs.
        while (beats_sent < 470) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) send_key($urandom_range(65, 140));
            else if (sel < 3) send_key(64);
            else send_key($urandom_range(0, 20));
            if ($urandom_range(0, 4) == 0) send_beat(KIND_UNUSED, 8'($urandom_range(0, 255)));
            send_data($urandom_range(0, 70));
            if ($urandom_range(0, 5) == 0) send_beat(KIND_KEY, 8'($urandom_range(0, 255)));
            send_beat(KIND_FINISH, 8'($urandom_range(0, 255)));
        end

        wait_drained();
        repeat (500) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: generous bound for about 600 beats including long hashes and stalls.
    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
